// ----- src/sidta_pkg.sv -----
// Shared constants and types for the signed integer to decimal ASCII unit.
package sidta_pkg;

   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 8;
   localparam int BCD_W       = 4;
   localparam int DIGIT_COUNT = 10;
   localparam int BIT_CNT_W   = $clog2(VALUE_W);
   localparam int IDX_W       = $clog2(DIGIT_COUNT);

   localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'h30;
   localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

endpackage

// ----- src/sidta_bcd_cell.sv -----
// One BCD digit cell of the shift-and-add-3 conversion chain.
module sidta_bcd_cell (
   input  logic                    clock,
   input  sidta_pkg::cell_ctrl_type ctrl,
   input  logic                    shift_in,
   output logic                    shift_out,
   output logic [3:0]              digit
);
   import sidta_pkg::*;

   logic [BCD_W-1:0] digit_ff;
   logic [BCD_W-1:0] digit_in;
   logic [BCD_W-1:0] adjusted;

   // Add 3 when the digit would overflow past 9 after doubling.
   assign adjusted  = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign shift_out = adjusted[BCD_W-1];
   assign digit     = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.shift) begin
         digit_in = {adjusted[BCD_W-2:0], shift_in};
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

// ----- src/signed_int_to_decimal_ascii_unit.sv -----
// Top level: signed 32-bit integer to decimal ASCII character stream.
// Each accepted item is converted to its decimal text, sent one character per
// result, most significant digit first, with a leading '-' for negative values
// and rsp_last on the final character. The magnitude is fed bit by bit into a
// row of ten BCD digit cells (shift-and-add-3) in 32 steps; a locate step then
// finds the leading digit, then 1 to 11 characters leave at one per
// cycle while the consumer keeps rsp_ready high. Most of an item's time in
// the block goes to the 32-step bit-serial conversion.
// A new item is taken as soon as the previous item's last character sits in
// the output register.
module signed_int_to_decimal_ascii_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [sidta_pkg::VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sidta_pkg::CHAR_W-1:0]   rsp_character,
   output logic                           rsp_last
);
   import sidta_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_CONVERT = 2'd1;
   localparam logic [1:0] ST_LOCATE  = 2'd2;
   localparam logic [1:0] ST_EMIT    = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [VALUE_W-1:0]   raw;
   logic                 accept;
   logic                 slot_free;
   cell_ctrl_type        cell_ctrl;
   logic [BCD_W-1:0]     digits [DIGIT_COUNT];
   logic [DIGIT_COUNT:0] carry;
   logic [IDX_W-1:0]     lead_idx;
   logic [BCD_W-1:0]     cur_digit;

   assign raw       = unsigned'(req_value);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign cell_ctrl.clear = accept;
   assign cell_ctrl.shift = (state_ff == ST_CONVERT);
   assign carry[0]        = mag_ff[VALUE_W-1];

   for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cells
      sidta_bcd_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .shift_in  (carry[g]),
         .shift_out (carry[g+1]),
         .digit     (digits[g])
      );
   end

   // Highest nonzero digit; zero input falls back to the units digit.
   always_comb begin
      lead_idx = '0;
      for (int i = 1; i < DIGIT_COUNT; i++) begin
         if (digits[i] != '0) begin
            lead_idx = IDX_W'(i);
         end
      end
   end

   assign cur_digit = digits[idx_ff];

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      bit_cnt_in   = bit_cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in     = raw[VALUE_W-1];
               mag_in     = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
               bit_cnt_in = '0;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            mag_in     = {mag_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            idx_in   = lead_idx;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_char_in = MINUS_CHAR;
                  rsp_last_in = 1'b0;
                  neg_in      = 1'b0;
               end else begin
                  rsp_char_in = DIGIT_BASE + CHAR_W'(cur_digit);
                  rsp_last_in = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff - 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      bit_cnt_ff  <= bit_cnt_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   a_accept_starts_convert: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CONVERT)
      else $error("accepted item did not start conversion");

   a_last_is_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_character >= DIGIT_BASE &&
                               rsp_character <= DIGIT_BASE + 8'd9)
      else $error("final character is not a digit");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == MINUS_CHAR |-> !rsp_last)
      else $error("minus sign flagged as last");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> idx_ff < IDX_W'(DIGIT_COUNT))
      else $error("digit index out of range");

endmodule
